>>> rtl/core/rfsw_pkg.sv
// Shared types and constants for the radio switch pulse-train encoder.
// No dependencies; imported by every module of the block.
package rfsw_pkg;

   // Field widths
   localparam int unsigned ID_W     = 5;
   localparam int unsigned UNIT_W   = 5;
   localparam int unsigned SHORT_W  = 11;
   localparam int unsigned LONGM_W  = 4;
   localparam int unsigned FOOTM_W  = 6;
   localparam int unsigned DUR_W    = 17;
   localparam int unsigned IDX_W    = 6;
   localparam int unsigned CSR_A_W  = 2;
   localparam int unsigned CSR_D_W  = 11;
   localparam int unsigned REQ_D_W  = 16;
   localparam int unsigned RSP_D_W  = 24;

   // Frame layout
   localparam logic [IDX_W-1:0] LAST_SYMBOL_PULSE = 6'd47;
   localparam logic [IDX_W-1:0] FOOTER_SHORT_IDX  = 6'd48;
   localparam logic [IDX_W-1:0] FOOTER_GAP_IDX    = 6'd49;

   // Symbol slots that carry the unit, id and state bits
   localparam logic [3:0] UNIT_SYMBOLS  = 4'd5;
   localparam logic [3:0] ID_SYMBOLS_END = 4'd10;
   localparam logic [3:0] OFF_SYMBOL    = 4'd10;
   localparam logic [3:0] ID_BASE_SYM   = 4'd5;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_SHORT_LEN = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_LONG_MULT = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_FOOT_MULT = 2'd2;

   // Register reset values
   localparam logic [SHORT_W-1:0] SHORT_LEN_RST = 11'd300;
   localparam logic [LONGM_W-1:0] LONG_MULT_RST = 4'd3;
   localparam logic [FOOTM_W-1:0] FOOT_MULT_RST = 6'd31;

   // Symbol kinds
   typedef enum logic [1:0] {
      KIND_LOW  = 2'd0,
      KIND_MED  = 2'd1,
      KIND_HIGH = 2'd2
   } kind_type;

   // Timing registers as seen by the pulse stage
   typedef struct packed {
      logic [SHORT_W-1:0] short_len;
      logic [LONGM_W-1:0] long_mult;
      logic [FOOTM_W-1:0] foot_mult;
   } cfg_type;

   // One pulse to be sized: position in frame plus the held command
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  index;
      logic [ID_W-1:0]   id;
      logic [UNIT_W-1:0] unit;
      logic              state;
   } pulse_desc_type;

endpackage

>>> rtl/core/rf_switch_pulse_train_encoder.sv
// Radio switch pulse-train encoder: one command in, a 50-pulse frame out.
// A command is held in the frame sequencer's registers, then each pulse in the
// pulse stage's output register. Throughput: one pulse per cycle while
// rsp_tready is high, as the sequencer's pulse counter steps; the next command
// loads as the last pulse enters the output register. Synchronous active-high
// reset clears control state and returns the timing registers to 300, 3 and 31.
module rf_switch_pulse_train_encoder import rfsw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Command stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_D_W-1:0] req_tdata,   // device_id[4:0], unit_code[9:5], switch_on[10]
   // Pulse stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_D_W-1:0] rsp_tdata,   // pulse_duration[16:0], pulse_index[22:17]
   output logic               rsp_tlast,
   // Register write port
   input  logic               csr_wr_en,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_D_W-1:0] csr_wr_data
);

   logic [SHORT_W-1:0] short_len_ff;
   logic [LONGM_W-1:0] long_mult_ff;
   logic [FOOTM_W-1:0] foot_mult_ff;
   cfg_type            cfg;
   pulse_desc_type     desc;
   logic               desc_ready;
   logic [DUR_W-1:0]   duration;
   logic [IDX_W-1:0]   index;

   // Timing registers; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff <= SHORT_LEN_RST;
         long_mult_ff <= LONG_MULT_RST;
         foot_mult_ff <= FOOT_MULT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_SHORT_LEN: short_len_ff <= csr_wr_data;
            CSR_LONG_MULT: long_mult_ff <= csr_wr_data[LONGM_W-1:0];
            CSR_FOOT_MULT: foot_mult_ff <= csr_wr_data[FOOTM_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.short_len = short_len_ff;
   assign cfg.long_mult = long_mult_ff;
   assign cfg.foot_mult = foot_mult_ff;

   rfsw_frame_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .cmd_id     (req_tdata[4:0]),
      .cmd_unit   (req_tdata[9:5]),
      .cmd_state  (req_tdata[10]),
      .desc       (desc),
      .desc_ready (desc_ready)
   );

   rfsw_pulse_gen u_gen (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .desc         (desc),
      .desc_ready   (desc_ready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_duration (duration),
      .rsp_index    (index),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, index, duration};

endmodule

>>> rtl/core/rfsw_frame_seq.sv
// Frame sequencer: holds the current command and steps the pulse position.
// Depends on rfsw_pkg.
module rfsw_frame_seq import rfsw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  logic [ID_W-1:0]   cmd_id,
   input  logic [UNIT_W-1:0] cmd_unit,
   input  logic              cmd_state,
   output pulse_desc_type    desc,
   input  logic              desc_ready
);

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              state_ff, state_in;
   logic              advance;
   logic              frame_done;
   logic              load;

   // Advance one pulse whenever the pulse stage can take it
   assign advance    = busy_ff && desc_ready;
   assign frame_done = advance && (cnt_ff == FOOTER_GAP_IDX);
   assign cmd_ready  = !busy_ff || frame_done;
   assign load       = cmd_valid && cmd_ready;

   // Next state of the sequencer
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      id_in    = id_ff;
      unit_in  = unit_ff;
      state_in = state_ff;
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         id_in    = cmd_id;
         unit_in  = cmd_unit;
         state_in = cmd_state;
      end else if (frame_done) begin
         busy_in = 1'b0;
         cnt_in  = '0;
      end else if (advance) begin
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         id_ff    <= '0;
         unit_ff  <= '0;
         state_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         id_ff    <= id_in;
         unit_ff  <= unit_in;
         state_ff <= state_in;
      end
   end

   assign desc.valid = busy_ff;
   assign desc.index = cnt_ff;
   assign desc.id    = id_ff;
   assign desc.unit  = unit_ff;
   assign desc.state = state_ff;

endmodule

>>> rtl/core/rfsw_pulse_gen.sv
// Pulse stage: decodes the symbol kind, sizes the pulse and registers the result.
// Depends on rfsw_pkg.
module rfsw_pulse_gen import rfsw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  pulse_desc_type   desc,
   output logic             desc_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [DUR_W-1:0] rsp_duration,
   output logic [IDX_W-1:0] rsp_index,
   output logic             rsp_last
);

   logic             valid_ff, valid_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic [IDX_W-1:0] idx_ff;
   logic             last_ff;
   logic [3:0]       sym;
   logic [1:0]       pos;
   logic [3:0]       id_sym;
   kind_type         kind;
   logic             long_pulse;
   logic [FOOTM_W-1:0] mult;
   logic             take;

   assign sym    = desc.index[5:2];
   assign pos    = desc.index[1:0];
   assign id_sym = sym - ID_BASE_SYM;

   // Pick the symbol kind for this slot
   always_comb begin
      if (sym < UNIT_SYMBOLS) begin
         kind = desc.unit[sym[2:0]] ? KIND_MED : KIND_LOW;
      end else if (sym < ID_SYMBOLS_END) begin
         kind = desc.id[id_sym[2:0]] ? KIND_HIGH : KIND_LOW;
      end else if (sym == OFF_SYMBOL) begin
         kind = desc.state ? KIND_LOW : KIND_HIGH;
      end else begin
         kind = desc.state ? KIND_HIGH : KIND_LOW;
      end
   end

   // Long or short within the four-pulse pattern
   always_comb begin
      unique case (kind)
         KIND_MED:  long_pulse = (pos == 2'd0) || (pos == 2'd2);
         KIND_HIGH: long_pulse = (pos == 2'd1) || (pos == 2'd3);
         default:   long_pulse = (pos == 2'd1) || (pos == 2'd2);
      endcase
   end

   // Multiplier of the short pulse for this position
   always_comb begin
      if (desc.index == FOOTER_SHORT_IDX) begin
         mult = 6'd1;
      end else if (desc.index == FOOTER_GAP_IDX) begin
         mult = cfg.foot_mult;
      end else if (long_pulse) begin
         mult = {2'b00, cfg.long_mult};
      end else begin
         mult = 6'd1;
      end
   end

   assign dur_in = {{(DUR_W-SHORT_W){1'b0}}, cfg.short_len}
                 * {{(DUR_W-FOOTM_W){1'b0}}, mult};

   // Output register: refill when empty or when the held transaction leaves
   assign desc_ready = !valid_ff || rsp_ready;
   assign take       = desc.valid && desc_ready;

   always_comb begin
      valid_in = valid_ff;
      if (desc_ready) begin
         valid_in = desc.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dur_ff  <= dur_in;
         idx_ff  <= desc.index;
         last_ff <= (desc.index == FOOTER_GAP_IDX);
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_duration = dur_ff;
   assign rsp_index    = idx_ff;
   assign rsp_last     = last_ff;

endmodule
